// ----- sv/pba_pkg.sv -----
`default_nettype none

package pba_pkg;

    localparam int MODE_W     = 1;
    localparam int POSITION_W = 13;
    localparam int VALUE_W    = 13;
    localparam int ERROR_W    = 2;

    localparam logic [MODE_W-1:0] MODE_READ  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 1'b1;

    localparam logic [ERROR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERROR_W-1:0] ERR_POSITION = 2'd1;
    localparam logic [ERROR_W-1:0] ERR_VALUE    = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [POSITION_W-1:0] position;
        logic [VALUE_W-1:0]    value;
        logic                  clear_first;
    } pba_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [ERROR_W-1:0] error;
    } pba_rsp_t;

endpackage

`default_nettype wire

// ----- sv/pba_req_if.sv -----
`default_nettype none

interface pba_req_if import pba_pkg::*; ();
    logic     valid;
    logic     ready;
    pba_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/pba_rsp_if.sv -----
`default_nettype none

interface pba_rsp_if import pba_pkg::*; ();
    logic     valid;
    logic     ready;
    pba_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/pba_ram.sv -----
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/packed_bitfield_array.sv -----
`default_nettype none

// Packed field store: ENTRIES fields of FIELD_BITS bits, MSB first, back to back in
// WORD_BITS-bit words of one RAM (one write and one registered read port). After
// reset a clearing pass zeroes all ceil(FIELD_BITS*min(ENTRIES,8192)/WORD_BITS)
// words, one per cycle, and no beat is taken meanwhile.
// One beat at a time: a valid access runs from accept through a step forming the word
// index of the bit address by a reciprocal multiply, one forming the bit offset and
// issuing the first word read, one step per word the field touches (each read through
// the shared shift/merge path and, in write mode, written back merged), and one that
// loads the output register. A refused beat (position or value error) goes from accept
// straight to that output step. The result sits in an output register, and the next
// beat is accepted while it waits; a result that finds that register still full holds
// the block until the waiting beat is taken.
module packed_bitfield_array import pba_pkg::*; #(
    parameter int FIELD_BITS = 13,
    parameter int WORD_BITS  = 16,
    parameter int ENTRIES    = 8192
) (
    input wire logic clk,
    input wire logic rst_n,
    pba_req_if.sink   req,
    pba_rsp_if.source rsp
);

    localparam int POS_LIMIT   = 1 << POSITION_W;
    localparam int EFF_ENTRIES = (ENTRIES < POS_LIMIT) ? ENTRIES : POS_LIMIT;
    localparam int TOTAL_BITS  = FIELD_BITS * EFF_ENTRIES;
    localparam int NUM_WORDS   = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW          = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int GBW         = (TOTAL_BITS > 1) ? $clog2(TOTAL_BITS) : 1;
    localparam int OW          = $clog2(WORD_BITS);
    localparam int MAXW        = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int SW          = $clog2(MAXW + 1);
    localparam int RSH         = GBW + OW;
    localparam int PW          = 2 * GBW + 1;
    // ceil(2^RSH / WORD_BITS): exact quotient for every bit address below 2^GBW
    localparam logic [GBW:0] RECIP =
        (GBW+1)'(((64'd1 << RSH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
    localparam logic [VALUE_W-1:0] VALUE_HIGH = (FIELD_BITS >= VALUE_W) ? '0 :
        ~VALUE_W'((64'd1 << FIELD_BITS) - 64'd1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_READ  = 6'b001000,
        ST_MERGE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [SW-1:0]         rcnt_reg, rcnt_next;
    logic                  out_valid_reg, out_valid_next;

    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic                  clear_reg, clear_next;
    logic [ERROR_W-1:0]    err_reg, err_next;
    logic [FIELD_BITS-1:0] acc_reg, acc_next;
    logic [FIELD_BITS-1:0] vsh_reg, vsh_next;
    logic [GBW-1:0]        dvd_reg, dvd_next;
    logic [GBW-1:0]        quot_reg, quot_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [OW-1:0]         off_reg, off_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [ERROR_W-1:0]    out_error_reg, out_error_next;

    // word index by reciprocal multiply, offset from the word base
    logic [PW-1:0]         prod;
    logic [GBW-1:0]        word_base;

    // shift/merge path
    logic [SW-1:0]         avail, take, sh;
    logic [WORD_BITS-1:0]  rdata, seg, field_mask, new_bits, merged;
    logic [FIELD_BITS-1:0] seg_val;

    logic                  pos_bad, val_bad;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata;

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.data.read_value = out_value_reg;
    assign rsp.data.error      = out_error_reg;

    assign pos_bad = 32'(req.data.position) >= 32'(ENTRIES);
    assign val_bad = (req.data.mode == MODE_WRITE) && ((req.data.value & VALUE_HIGH) != '0);

    assign prod      = PW'(dvd_reg) * PW'(RECIP);
    assign word_base = GBW'(quot_reg * GBW'(WORD_BITS));

    // bits of this word that belong to the field: MSB index off .. off+take-1
    assign avail      = SW'(WORD_BITS) - SW'(off_reg);
    assign take       = (avail < rcnt_reg) ? avail : rcnt_reg;
    assign sh         = avail - take;
    assign field_mask = ~({WORD_BITS{1'b1}} << take) << sh;
    assign seg        = (rdata >> sh) & ~({WORD_BITS{1'b1}} << take);
    assign seg_val    = vsh_reg >> (SW'(FIELD_BITS) - take);
    assign new_bits   = WORD_BITS'(seg_val) << sh;
    assign merged     = clear_reg ? ((rdata & ~field_mask) | new_bits) : (rdata | new_bits);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rcnt_next      = rcnt_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        clear_next     = clear_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        vsh_next       = vsh_reg;
        dvd_next       = dvd_reg;
        quot_next      = quot_reg;
        addr_next      = addr_reg;
        off_next       = off_reg;
        out_value_next = out_value_reg;
        out_error_next = out_error_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = merged;
        ram_raddr = addr_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.data.mode;
                    clear_next = req.data.clear_first;
                    acc_next   = '0;
                    vsh_next   = FIELD_BITS'(req.data.value);
                    dvd_next   = GBW'(32'(req.data.position) * 32'(FIELD_BITS));
                    quot_next  = '0;
                    if (pos_bad)
                    begin
                        err_next   = ERR_POSITION;
                        state_next = ST_DONE;
                    end
                    else if (val_bad)
                    begin
                        err_next   = ERR_VALUE;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = ERR_OK;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                quot_next  = GBW'(prod >> RSH);
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_raddr  = AW'(quot_reg);
                addr_next  = AW'(quot_reg);
                off_next   = OW'(dvd_reg - word_base);
                rcnt_next  = SW'(FIELD_BITS);
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (mode_reg == MODE_READ)
                begin
                    acc_next = (acc_reg << take) | FIELD_BITS'(seg);
                end
                else
                begin
                    ram_we = 1'b1;
                end
                vsh_next  = vsh_reg << take;
                rcnt_next = rcnt_reg - take;
                off_next  = '0;
                if (rcnt_reg == take)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // prefetch the next word while this one is written back
                    ram_raddr = addr_reg + AW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_error_next = err_reg;
                    out_value_next = (err_reg == ERR_OK && mode_reg == MODE_READ) ?
                                     VALUE_W'(acc_reg) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rcnt_reg      <= rcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        clear_reg     <= clear_next;
        err_reg       <= err_next;
        acc_reg       <= acc_next;
        vsh_reg       <= vsh_next;
        dvd_reg       <= dvd_next;
        quot_reg      <= quot_next;
        addr_reg      <= addr_next;
        off_reg       <= off_next;
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
    end

endmodule

`default_nettype wire
